// File: rtl/mgqm_pkg.sv
// ----------------------------------------------------------------------------
// mgqm_pkg
// Shared types and constants of the masked grouped quantized matrix-vector
// block: transaction payloads, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mgqm_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS         = 2'd2;

   // Raw register widths
   localparam int COLUMNS_W      = 13;
   localparam int GROUP_LENGTH_W = 9;
   localparam int ROWS_W         = 13;

   // Register reset values
   localparam logic [COLUMNS_W-1:0]      RESET_COLUMNS      = 13'd4096;
   localparam logic [GROUP_LENGTH_W-1:0] RESET_GROUP_LENGTH = 9'd32;
   localparam logic [ROWS_W-1:0]         RESET_ROWS         = 13'd1;

   // Payload widths
   localparam int VALUE_W = 56;
   localparam int INDEX_W = 12;

   // Input transaction: one matrix element
   typedef struct packed {
      logic [1:0]         weight_code;
      logic signed [15:0] activation;
      logic               keep;
      logic signed [15:0] group_scale;
      logic signed [15:0] group_bias;
   } req_type;

   // Result transaction: one finished row
   typedef struct packed {
      logic signed [VALUE_W-1:0] row_value;
      logic [INDEX_W-1:0]        row_index;
      logic                      last_row;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/mgqm_full_cols.sv
// ----------------------------------------------------------------------------
// mgqm_full_cols
// Computes the number of columns covered by full groups,
// dividend - (dividend mod divisor), with a restoring division that retires
// one dividend bit per cycle, then forms the result in a final step.
// ----------------------------------------------------------------------------
`default_nettype none

module mgqm_full_cols #(
   parameter int DW = 13,
   parameter int VW = 9
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           start,
   input  wire  [DW-1:0] dividend,
   input  wire  [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] full_cols
);

   localparam int CntW = $clog2(DW + 2);

   logic [CntW-1:0] cnt_ff,  cnt_in;
   logic [DW-1:0]   dvd_ff,  dvd_in;
   logic [VW-1:0]   rem_ff,  rem_in;
   logic [DW-1:0]   full_ff, full_in;
   logic [VW:0]     trial;

   assign busy      = (cnt_ff != '0);
   assign full_cols = full_ff;

   // Shift in the next dividend bit and subtract the divisor where it fits
   assign trial = {rem_ff, dvd_ff[DW-1]};

   always_comb begin
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      full_in = full_ff;
      if (start) begin
         cnt_in = CntW'(DW + 1);
         dvd_in = dividend;
         rem_in = '0;
      end else if (cnt_ff > CntW'(1)) begin
         cnt_in = cnt_ff - CntW'(1);
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = VW'(trial - {1'b0, divisor});
         end else begin
            rem_in = VW'(trial);
         end
      end else if (cnt_ff == CntW'(1)) begin
         cnt_in  = '0;
         full_in = dividend - DW'(rem_ff);
      end
   end

   // Hold control under reset, payload free running
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      full_ff <= full_in;
   end

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("full column unit idle after start");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy && !start |-> ({1'b0, rem_ff} < {1'b0, divisor}))
      else $error("partial remainder not below divisor");

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |-> full_ff <= dividend)
      else $error("full column count exceeds columns");

endmodule

`default_nettype wire

// File: rtl/masked_grouped_quant_matvec_top.sv
// Path: the element that ends a row passes the input register, then the
//   result register, which holds the row result; stalls can hold either.
// Throughput: one element per cycle via the combinational accumulate path,
//   unless a full-group count or a held row result stalls it. Reset and every
//   write of columns or group_length start such a count, with req_ready low.
// Reset is synchronous, active high; registers return to their defaults.
// ----------------------------------------------------------------------------
// masked_grouped_quant_matvec_top
// Streams a matrix row by row, one element per transaction, and emits the
// masked, group-dequantized dot product of each row.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_grouped_quant_matvec_top #(
   parameter int MAX_COLUMNS = 4096,
   parameter int MAX_GROUP   = 256,
   parameter int MAX_ROWS    = 4096
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  mgqm_pkg::req_type               req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output mgqm_pkg::rsp_type                     rsp_data,
   input  wire                                   csr_we,
   input  wire  [mgqm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [mgqm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int ColW  = $clog2(MAX_COLUMNS + 1);
   localparam int CpW   = $clog2(MAX_COLUMNS);
   localparam int GlW   = $clog2(MAX_GROUP + 1);
   localparam int GpW   = $clog2(MAX_GROUP);
   localparam int NrW   = $clog2(MAX_ROWS + 1);
   localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DotW  = 19 + $clog2(MAX_GROUP);
   localparam int SumW  = 17 + $clog2(MAX_GROUP);
   localparam int ValW  = mgqm_pkg::VALUE_W;

   // Configuration registers
   logic [mgqm_pkg::COLUMNS_W-1:0]      cols_ff,    cols_in;
   logic [mgqm_pkg::GROUP_LENGTH_W-1:0] glen_ff,    glen_in;
   logic [mgqm_pkg::ROWS_W-1:0]         rows_ff,    rows_in;
   logic                                restart_ff, restart_in;

   // Input register
   logic                   s1_valid_ff, s1_valid_in;
   mgqm_pkg::req_type      s1_data_ff,  s1_data_in;

   // Row state
   logic [CpW-1:0]         cp_ff,      cp_in;
   logic [GpW-1:0]         gp_ff,      gp_in;
   logic signed [DotW-1:0] dot_ff,     dot_in;
   logic signed [SumW-1:0] sum_ff,     sum_in;
   logic [ValW-1:0]        row_acc_ff, row_acc_in;
   logic [RowW-1:0]        rc_ff,      rc_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   mgqm_pkg::rsp_type      rsp_data_ff,  rsp_data_in;

   logic [ColW-1:0]        ncols;
   logic [GlW-1:0]         glen;
   logic [NrW-1:0]         nrows;
   logic [ColW-1:0]        full_cols;
   logic                   div_busy;
   logic                   cfg_busy;
   logic                   s1_fire;
   logic                   in_full;
   logic                   group_end;
   logic                   row_end;
   logic                   last;
   logic signed [17:0]     wx;
   logic signed [DotW-1:0] dot_upd;
   logic signed [SumW-1:0] sum_upd;
   logic signed [DotW+15:0] prod_dot;
   logic signed [SumW+15:0] prod_sum;
   logic [ValW-1:0]        term;
   logic [ValW-1:0]        row_acc_upd;

   // Write registers; columns or group_length writes restart full-group count
   always_comb begin
      cols_in    = cols_ff;
      glen_in    = glen_ff;
      rows_in    = rows_ff;
      restart_in = 1'b0;
      if (csr_we) begin
         case (csr_index)
            mgqm_pkg::CSR_COLUMNS: begin
               cols_in    = csr_wdata[mgqm_pkg::COLUMNS_W-1:0];
               restart_in = 1'b1;
            end
            mgqm_pkg::CSR_GROUP_LENGTH: begin
               glen_in    = csr_wdata[mgqm_pkg::GROUP_LENGTH_W-1:0];
               restart_in = 1'b1;
            end
            mgqm_pkg::CSR_ROWS: begin
               rows_in = csr_wdata[mgqm_pkg::ROWS_W-1:0];
            end
            default: begin
               restart_in = 1'b0;
            end
         endcase
      end
   end

   // Clamp register values into their working ranges
   always_comb begin
      if (cols_ff == '0) begin
         ncols = ColW'(1);
      end else if (int'(cols_ff) > MAX_COLUMNS) begin
         ncols = ColW'(MAX_COLUMNS);
      end else begin
         ncols = ColW'(cols_ff);
      end
      if (glen_ff == '0) begin
         glen = GlW'(1);
      end else if (int'(glen_ff) > MAX_GROUP) begin
         glen = GlW'(MAX_GROUP);
      end else begin
         glen = GlW'(glen_ff);
      end
      if (rows_ff == '0) begin
         nrows = NrW'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         nrows = NrW'(MAX_ROWS);
      end else begin
         nrows = NrW'(rows_ff);
      end
   end

   mgqm_full_cols #(
      .DW (ColW),
      .VW (GlW)
   ) u_full_cols (
      .clock     (clock),
      .reset     (reset),
      .start     (restart_ff),
      .dividend  (ncols),
      .divisor   (glen),
      .busy      (div_busy),
      .full_cols (full_cols)
   );

   assign cfg_busy = restart_ff || div_busy;

   // Advance the held element if the result register is free and cfg_busy low
   assign s1_fire   = s1_valid_ff && !cfg_busy && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !cfg_busy && (!s1_valid_ff || s1_fire);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Element contribution and group term
   assign in_full   = ColW'(cp_ff) < full_cols;
   assign group_end = (GlW'(gp_ff) + GlW'(1)) >= glen;
   assign row_end   = (ColW'(cp_ff) + ColW'(1)) >= ncols;
   assign last      = (NrW'(rc_ff) + NrW'(1)) >= nrows;

   assign wx       = $signed({1'b0, s1_data_ff.weight_code}) * s1_data_ff.activation;
   assign dot_upd  = s1_data_ff.keep ? (dot_ff + DotW'(wx)) : dot_ff;
   assign sum_upd  = s1_data_ff.keep ? (sum_ff + SumW'(s1_data_ff.activation)) : sum_ff;
   assign prod_dot = s1_data_ff.group_scale * dot_upd;
   assign prod_sum = s1_data_ff.group_bias * sum_upd;
   assign term     = ValW'(prod_dot) + ValW'(prod_sum);

   assign row_acc_upd = (in_full && group_end) ? (row_acc_ff + term) : row_acc_ff;

   // Update row state and load the result on a row end
   always_comb begin
      cp_in        = cp_ff;
      gp_in        = gp_ff;
      dot_in       = dot_ff;
      sum_in       = sum_ff;
      row_acc_in   = row_acc_ff;
      rc_in        = rc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire) begin
         if (in_full) begin
            if (group_end) begin
               row_acc_in = row_acc_upd;
               dot_in     = '0;
               sum_in     = '0;
               gp_in      = '0;
            end else begin
               dot_in = dot_upd;
               sum_in = sum_upd;
               gp_in  = gp_ff + GpW'(1);
            end
         end
         if (row_end) begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.row_value = row_acc_upd;
            rsp_data_in.row_index = mgqm_pkg::INDEX_W'(rc_ff);
            rsp_data_in.last_row  = last;
            row_acc_in            = '0;
            dot_in                = '0;
            sum_in                = '0;
            gp_in                 = '0;
            cp_in                 = '0;
            rc_in                 = last ? '0 : (rc_ff + RowW'(1));
         end else begin
            cp_in = cp_ff + CpW'(1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Reset control and state: defaults into registers, row state cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= mgqm_pkg::RESET_COLUMNS;
         glen_ff      <= mgqm_pkg::RESET_GROUP_LENGTH;
         rows_ff      <= mgqm_pkg::RESET_ROWS;
         restart_ff   <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cp_ff        <= '0;
         gp_ff        <= '0;
         dot_ff       <= '0;
         sum_ff       <= '0;
         row_acc_ff   <= '0;
         rc_ff        <= '0;
      end else begin
         cols_ff      <= cols_in;
         glen_ff      <= glen_in;
         rows_ff      <= rows_in;
         restart_ff   <= restart_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cp_ff        <= cp_in;
         gp_ff        <= gp_in;
         dot_ff       <= dot_in;
         sum_ff       <= sum_in;
         row_acc_ff   <= row_acc_in;
         rc_ff        <= rc_in;
      end
   end

   // Hold payload registers without reset
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !s1_fire)
      else $error("pending row result overwritten");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(row_acc_ff) && $stable(cp_ff) && $stable(rc_ff))
      else $error("row state moved without an element");

   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      s1_fire && row_end |=> cp_ff == '0 && gp_ff == '0 && row_acc_ff == '0)
      else $error("row state not cleared at row end");

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the masked grouped quantized matrix-vector block. A built-in
// row predictor follows every accepted element. Each row result is checked
// field by field against the oldest prediction. Directed phases cover field
// extremes, ignored tail columns, groups longer than the row, clamped
// registers and register changes in the middle of a row. A row of largest
// groups, a long result hold-off and random matrices with random idling follow.
// ----------------------------------------------------------------------------

module tb;

   localparam int MAX_COLUMNS     = 4096;
   localparam int MAX_GROUP       = 256;
   localparam int MAX_ROWS        = 4096;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_CYCLES     = 200;
   localparam int RANDOM_ELEMENTS = 650;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int TIMEOUT_NS      = 2_000_000;

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   mgqm_pkg::req_type                req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   mgqm_pkg::rsp_type                rsp_data;
   logic                             csr_we    = 1'b0;
   logic [mgqm_pkg::CSR_INDEX_W-1:0] csr_index = mgqm_pkg::CSR_COLUMNS;
   logic [mgqm_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Idling controls: calm turns random idling off, holding stalls results
   logic calm    = 1'b0;
   logic holding = 1'b0;

   // Predictor copy of the registers (raw stored values) and the row state
   int                 cols_reg = int'(mgqm_pkg::RESET_COLUMNS);
   int                 glen_reg = int'(mgqm_pkg::RESET_GROUP_LENGTH);
   int                 rows_reg = int'(mgqm_pkg::RESET_ROWS);
   int                 col_pos  = 0;
   int                 grp_pos  = 0;
   int                 row_cnt  = 0;
   longint             dot_sum  = 0;
   longint             x_sum    = 0;
   logic signed [55:0] row_sum  = '0;

   mgqm_pkg::rsp_type pending_rows[$];
   int                elements_sent = 0;
   int                rows_checked  = 0;
   int                mismatches    = 0;

   masked_grouped_quant_matvec_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Register value as the block uses it: zero acts as one, cap at the maximum
   function automatic int effective(input int raw, input int top);
      if (raw == 0) return 1;
      return (raw > top) ? top : raw;
   endfunction

   // Advance the row state by one element; queue the row value at row end
   function automatic void accumulate_element(input mgqm_pkg::req_type e);
      int                ncols, glen, nrows, full_cols;
      longint            w, x, term;
      mgqm_pkg::rsp_type r;
      ncols     = effective(cols_reg, MAX_COLUMNS);
      glen      = effective(glen_reg, MAX_GROUP);
      nrows     = effective(rows_reg, MAX_ROWS);
      full_cols = (ncols / glen) * glen;
      w         = longint'(e.weight_code);
      x         = longint'($signed(e.activation));
      if (col_pos < full_cols) begin
         if (e.keep) begin
            dot_sum += w * x;
            x_sum   += x;
         end
         if (grp_pos + 1 >= glen) begin
            term    = longint'($signed(e.group_scale)) * dot_sum
                    + longint'($signed(e.group_bias)) * x_sum;
            row_sum = row_sum + term[55:0];
            dot_sum = 0;
            x_sum   = 0;
            grp_pos = 0;
         end else begin
            grp_pos++;
         end
      end
      if (col_pos + 1 >= ncols) begin
         r.row_value = row_sum;
         r.row_index = row_cnt[mgqm_pkg::INDEX_W-1:0];
         r.last_row  = (row_cnt + 1 >= nrows);
         pending_rows.push_back(r);
         row_sum = '0;
         dot_sum = 0;
         x_sum   = 0;
         grp_pos = 0;
         col_pos = 0;
         row_cnt = r.last_row ? 0 : row_cnt + 1;
      end else begin
         col_pos++;
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns mismatch in %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Check results and predict from accepted elements, both at the clock edge
   always @(posedge clock) begin : scoreboard
      mgqm_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rows_checked++;
            if (pending_rows.size() == 0) begin
               report_mismatch("row with no prediction", rsp_data.row_value, 0);
            end else begin
               want = pending_rows.pop_front();
               if (rsp_data.row_value !== want.row_value)
                  report_mismatch("row_value", rsp_data.row_value, want.row_value);
               if (rsp_data.row_index !== want.row_index)
                  report_mismatch("row_index", rsp_data.row_index, want.row_index);
               if (rsp_data.last_row !== want.last_row)
                  report_mismatch("last_row", rsp_data.last_row, want.last_row);
            end
         end
         if (req_valid && req_ready) begin
            elements_sent++;
            accumulate_element(req_data);
         end
      end
   end

   // Result side: stall at random, hold off on request
   always @(posedge clock) begin
      if (reset || holding) begin
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 6);
      end
   end

   function automatic mgqm_pkg::req_type make_element(input logic [1:0] w,
                                                      input logic [15:0] x,
                                                      input logic k,
                                                      input logic [15:0] s,
                                                      input logic [15:0] b);
      mgqm_pkg::req_type e;
      e.weight_code = w;
      e.activation  = x;
      e.keep        = k;
      e.group_scale = s;
      e.group_bias  = b;
      return e;
   endfunction

   // Random 16-bit field with extra weight on the extremes and zero
   function automatic logic [15:0] random_word();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic mgqm_pkg::req_type random_element(input int keep_pct);
      return make_element(2'($urandom_range(3)), random_word(),
                          ($urandom_range(99) < keep_pct), random_word(), random_word());
   endfunction

   // Offer one element and hold it until the transaction completes
   task automatic send_element(input mgqm_pkg::req_type e);
      while (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted row has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rows.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [mgqm_pkg::CSR_INDEX_W-1:0] index,
                                 input int value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[mgqm_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      case (index)
         mgqm_pkg::CSR_COLUMNS:      cols_reg = value & 32'h1FFF;
         mgqm_pkg::CSR_GROUP_LENGTH: glen_reg = value & 32'h1FF;
         mgqm_pkg::CSR_ROWS:         rows_reg = value & 32'h1FFF;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input int cols, input int glen, input int nrows);
      write_register(mgqm_pkg::CSR_COLUMNS, cols);
      write_register(mgqm_pkg::CSR_GROUP_LENGTH, glen);
      write_register(mgqm_pkg::CSR_ROWS, nrows);
   endtask

   // Extreme weights, activations, scales and biases, with masked columns
   task automatic test_field_extremes();
      configure(4, 2, 3);
      send_element(make_element(2'd3, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF));
      send_element(make_element(2'd3, 16'h8000, 1'b1, 16'h8000, 16'h8000));
      send_element(make_element(2'd0, 16'h7FFF, 1'b1, 16'h0000, 16'h0000));
      send_element(make_element(2'd2, 16'h0001, 1'b1, 16'h8000, 16'h7FFF));
      send_element(make_element(2'd1, 16'h8000, 1'b0, 16'h1234, 16'hFFFF));
      send_element(make_element(2'd3, 16'h8000, 1'b1, 16'h7FFF, 16'h8000));
      send_element(make_element(2'd0, 16'h0000, 1'b0, 16'hFFFF, 16'h0001));
      send_element(make_element(2'd3, 16'hFFFF, 1'b1, 16'h7FFF, 16'h8000));
      settle();
   endtask

   // Columns past the last full group must not contribute
   task automatic test_ignored_tail();
      configure(5, 2, 3);
      repeat (4) send_element(random_element(100));
      send_element(make_element(2'd3, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF));
      settle();
   endtask

   // Group longer than the row: no full group, row value zero
   task automatic test_group_past_row();
      configure(2, 3, 3);
      repeat (2) send_element(make_element(2'd3, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF));
      settle();
   endtask

   // Zero in every register acts as one: each element is a full last row
   task automatic test_clamped_registers();
      configure(0, 0, 0);
      repeat (2) send_element(random_element(100));
      settle();
   endtask

   // Row counter past a newly lowered row count ends the matrix at once
   task automatic test_row_limit_change();
      configure(1, 1, 5);
      repeat (3) send_element(random_element(100));
      settle();
      write_register(mgqm_pkg::CSR_ROWS, 2);
      repeat (2) send_element(random_element(100));
      settle();
   endtask

   // Column and group positions past a new limit close the row or group
   task automatic test_midrow_changes();
      configure(8, 4, 4);
      repeat (6) send_element(random_element(80));
      settle();
      write_register(mgqm_pkg::CSR_COLUMNS, 3);
      send_element(random_element(100));
      settle();
      write_register(mgqm_pkg::CSR_COLUMNS, 8);
      repeat (2) send_element(random_element(100));
      settle();
      write_register(mgqm_pkg::CSR_GROUP_LENGTH, 1);
      send_element(random_element(100));
      settle();
   endtask

   // Two groups of the largest length, over-range group length and rows
   // clamped, largest magnitudes
   task automatic test_largest_sizes();
      configure(2 * MAX_GROUP, 511, 8191);
      repeat (2 * MAX_GROUP)
         send_element(make_element(2'd3, 16'h8000, 1'b1, 16'h8000, 16'h8000));
      settle();
   endtask

   // Hold results off for a long stretch while elements keep coming
   task automatic test_backpressure();
      int i;
      configure(1, 1, 16);
      calm    <= 1'b1;
      holding <= 1'b1;
      fork
         begin
            repeat (HOLD_CYCLES) @(posedge clock);
            holding <= 1'b0;
         end
         for (i = 0; i < 300; i++) send_element(random_element(90));
      join
      calm <= 1'b0;
      settle();
   endtask

   // Random matrices: mostly whole rows, some broken rows left mid-way
   task automatic test_random_traffic();
      int first_element, first_row, phase;
      int cols, glen, nrows, eff_cols, count, keep_pct, i;
      first_element = elements_sent;
      first_row     = rows_checked;
      phase         = 0;
      while (elements_sent - first_element < RANDOM_ELEMENTS
             || rows_checked - first_row < 48) begin
         settle();
         case ($urandom_range(9))
            0: cols = 0;
            1: cols = $urandom_range(100, 300);
            default: cols = $urandom_range(1, 40);
         endcase
         eff_cols = effective(cols, MAX_COLUMNS);
         case ($urandom_range(9))
            0: glen = 0;
            1: glen = eff_cols + $urandom_range(1, 8);
            2: glen = $urandom_range(257, 511);
            default: glen = $urandom_range(1, (eff_cols < 16) ? eff_cols : 16);
         endcase
         case ($urandom_range(9))
            0: nrows = 0;
            1: nrows = $urandom_range(MAX_ROWS + 1, 8191);
            default: nrows = $urandom_range(1, 6);
         endcase
         // one long stretch with no idling on either side
         calm <= (phase == 0);
         configure(cols, glen, nrows);
         keep_pct = ($urandom_range(3) == 0) ? 100 : $urandom_range(40, 95);
         if (phase == 0)
            count = eff_cols * (1 + 300 / eff_cols);
         else if ($urandom_range(5) == 0)
            count = $urandom_range(1, 2 * eff_cols);
         else
            count = eff_cols * $urandom_range(1, 3);
         for (i = 0; i < count; i++) send_element(random_element(keep_pct));
         phase++;
      end
      calm <= 1'b0;
   endtask

   initial begin : main_sequence
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (!req_ready) @(posedge clock);

      test_field_extremes();
      test_ignored_tail();
      test_group_past_row();
      test_clamped_registers();
      test_row_limit_change();
      test_midrow_changes();
      test_largest_sizes();
      test_backpressure();
      test_random_traffic();

      // Drain with a bound, then flag rows that never arrived
      req_valid <= 1'b0;
      for (n = 0; n < DRAIN_LIMIT && pending_rows.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_rows.size() != 0)
         report_mismatch("rows still outstanding", 0, pending_rows.size());

      $display("Checked %0d row results from %0d matrix elements", rows_checked, elements_sent);
      $display("Covered clamped and mid-row register changes, masking and result hold-off");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Run timed out with %0d rows outstanding", pending_rows.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: files.f
rtl/mgqm_pkg.sv
rtl/mgqm_full_cols.sv
rtl/masked_grouped_quant_matvec_top.sv
sim/tb.sv
